FILE: hdl/lpfr_pkg.sv
// Types and constants for the length-prefixed frame receiver.
// No dependencies; compiled first.

package lpfr_pkg;

  localparam logic [7:0] FRAME_DELIM = 8'h7E;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned FLEN_W     = 10;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_DROP   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_END     = 3'd4
  } phase_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         data_byte;
    logic [FLEN_W-1:0]  frame_length;
  } result_t;

  // Handshake between the parse step and the result register.
  typedef struct packed {
    logic advance;  // parse step consumes its held byte this cycle
    logic emit;     // and loads a result beat
  } step_ctl_t;

endpackage

FILE: hdl/lpfr_if.sv
// Valid/ready channel interfaces for the frame receiver.
// Depends on lpfr_pkg.

interface lpfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpfr_out_if import lpfr_pkg::*;;
  logic              valid;
  logic              ready;
  kind_t             kind;
  logic [7:0]        data_byte;
  logic [FLEN_W-1:0] frame_length;

  modport source (output valid, output kind, output data_byte, output frame_length,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input frame_length,
                  output ready);
endinterface

FILE: hdl/lpfr_in_stage.sv
// Input register: holds one received byte until the parse step takes it.
// Depends on lpfr_pkg.

module lpfr_in_stage import lpfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  step_ctl_t  ctl,
  output logic       hold_valid,
  output logic [7:0] hold_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       take;

  assign in_ready  = !valid_r || ctl.advance;
  assign take      = in_valid && in_ready;
  assign valid_nxt = take || (valid_r && !ctl.advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_byte;
    end
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

endmodule

FILE: hdl/lpfr_parser.sv
// Frame parse state machine and the accept-limit register.
// Depends on lpfr_pkg.

module lpfr_parser import lpfr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  input  logic             hold_valid,
  input  logic [7:0]       hold_byte,
  input  logic             sink_free,
  output step_ctl_t        ctl,
  output result_t          result
);

  localparam int unsigned     CNT_W   = $clog2(MAX_PAYLOAD + 1);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

  phase_t             phase_r, phase_nxt;
  logic [LEN_W-1:0]   decl_r, decl_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   cnt_inc;
  logic [LEN_W-1:0]   limit_r;
  logic [LEN_W-1:0]   len_lo;
  logic               emit;

  assign cnt_inc = cnt_r + CNT_W'(1);
  assign len_lo  = {decl_r[15:8], hold_byte};

  // next state
  always_comb begin
    phase_nxt = phase_r;
    decl_nxt  = decl_r;
    cnt_nxt   = cnt_r;
    case (phase_r)
      PH_LEN_HI: begin
        decl_nxt  = {hold_byte, 8'h00};
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        decl_nxt = len_lo;
        if (len_lo == '0 || len_lo > MAX_LEN) begin
          phase_nxt = PH_HUNT;
        end else begin
          cnt_nxt   = '0;
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        cnt_nxt = cnt_inc;
        if (LEN_W'(cnt_inc) >= decl_r) begin
          phase_nxt = PH_END;
        end
      end
      PH_END: begin
        phase_nxt = PH_HUNT;
      end
      default: begin
        phase_nxt = (hold_byte == FRAME_DELIM) ? PH_LEN_HI : PH_HUNT;
      end
    endcase
  end

  // outputs
  always_comb begin
    emit                = 1'b0;
    result.kind         = KIND_DATA;
    result.data_byte    = '0;
    result.frame_length = '0;
    case (phase_r)
      PH_PAYLOAD: begin
        emit             = 1'b1;
        result.data_byte = hold_byte;
      end
      PH_END: begin
        emit                = 1'b1;
        result.frame_length = decl_r[FLEN_W-1:0];
        result.kind = (hold_byte == FRAME_DELIM && decl_r <= limit_r) ? KIND_ACCEPT
                                                                       : KIND_DROP;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign ctl.advance = hold_valid && sink_free;
  assign ctl.emit    = ctl.advance && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      decl_r  <= '0;
      cnt_r   <= '0;
    end else if (ctl.advance) begin
      phase_r <= phase_nxt;
      decl_r  <= decl_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '1;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

endmodule

FILE: hdl/lpfr_out_stage.sv
// Result register: one beat held towards the consumer.
// Depends on lpfr_pkg.

module lpfr_out_stage import lpfr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  step_ctl_t ctl,
  input  result_t   result,
  output logic      sink_free,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   out_beat
);

  logic    valid_r, valid_nxt;
  result_t beat_r;

  assign sink_free = !valid_r || out_ready;
  assign valid_nxt = ctl.emit || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      beat_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

endmodule

FILE: hdl/length_prefixed_frame_receiver_unit.sv
// Top level of the length-prefixed frame receiver (cut-through deframer).
// Depends on lpfr_pkg, lpfr_if, lpfr_in_stage, lpfr_parser, lpfr_out_stage.
//
//   port     dir  beat contents                          notes
//   in_bus   in   rx_byte[7:0]                           one link byte per beat
//   out_bus  out  kind, data_byte[7:0], frame_length[9:0] payload byte or end marker
//   cfg_*    in   cfg_wr_data[15:0] = accept limit       write on cfg_wr_en
//
// One byte per clock sustained while out_bus is ready; an accepted byte is held in the
// input register, parsed into the result register and leaves on out_bus from there.
// Header bytes and hunted bytes give no beat, but still pass through the parse step.
// Reset (synchronous, rst_n low) empties both registers, returns the parser
// to hunting and sets the accept limit to 0xFFFF.
// An output stall holds the result register; one more byte is held in the
// input register before in_bus.ready drops.

module length_prefixed_frame_receiver_unit import lpfr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  logic             clk,
  input  logic             rst_n,
  lpfr_in_if.sink          in_bus,
  lpfr_out_if.source       out_bus,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data
);

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       sink_free;
  step_ctl_t  ctl;
  result_t    result;
  result_t    out_beat;

  // input register
  lpfr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_ready   (in_bus.ready),
    .in_byte    (in_bus.rx_byte),
    .ctl        (ctl),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  // parse step: phase, declared length, payload count
  lpfr_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .hold_valid  (hold_valid),
    .hold_byte   (hold_byte),
    .sink_free   (sink_free),
    .ctl         (ctl),
    .result      (result)
  );

  // result register
  lpfr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .result    (result),
    .sink_free (sink_free),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_beat  (out_beat)
  );

  assign out_bus.kind         = out_beat.kind;
  assign out_bus.data_byte    = out_beat.data_byte;
  assign out_bus.frame_length = out_beat.frame_length;

endmodule

FILE: tb/sv/lpfr_frame_checker.sv
// Checker for the length-prefixed frame receiver: watches both channels and the
// limit register, predicts every output beat and compares it field by field.
// Depends on lpfr_pkg.

module lpfr_frame_checker import lpfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              out_valid,
  input  logic              out_ready,
  input  kind_t             out_kind,
  input  logic [7:0]        out_data,
  input  logic [FLEN_W-1:0] out_len,
  input  logic              cfg_wr_en,
  input  logic [LEN_W-1:0]  cfg_wr_data,
  output int                fail_count,
  output int                pending,
  output int                payload_beats,
  output int                accepted_frames,
  output int                dropped_frames
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PAYLOAD = 512;

  // Shadow of the parser
  phase_t            ph;
  logic [LEN_W-1:0]  want_len;
  logic [9:0]        got_count;
  logic [LEN_W-1:0]  accept_limit;

  result_t expected_beats[$];

  // Advance the shadow parser by one link byte; returns 1 when a beat is due.
  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    r = '0;
    deframe_byte = 1'b0;
    case (ph)
      PH_LEN_HI: begin
        want_len = {b, 8'h00};
        ph = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        want_len[7:0] = b;
        if (want_len == 0 || want_len > MAX_PAYLOAD) begin
          ph = PH_HUNT;
        end else begin
          got_count = '0;
          ph = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        got_count = got_count + 1'b1;
        if (got_count >= want_len) ph = PH_END;
        r.kind = KIND_DATA;
        r.data_byte = b;
        deframe_byte = 1'b1;
      end
      PH_END: begin
        ph = PH_HUNT;
        if (b == FRAME_DELIM && want_len <= accept_limit) r.kind = KIND_ACCEPT;
        else r.kind = KIND_DROP;
        r.frame_length = want_len[FLEN_W-1:0];
        deframe_byte = 1'b1;
      end
      default: begin
        if (b == FRAME_DELIM) ph = PH_LEN_HI;
        else ph = PH_HUNT;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    bit      bad;
    if (!rst_n) begin
      ph = PH_HUNT;
      want_len = '0;
      got_count = '0;
      accept_limit = 16'hFFFF;
      expected_beats.delete();
    end else begin
      // Output side first: a byte accepted at this edge cannot leave at it.
      if (out_valid && out_ready) begin
        got.kind = out_kind;
        got.data_byte = out_data;
        got.frame_length = out_len;
        if (got.kind == KIND_DATA) payload_beats++;
        else if (got.kind == KIND_ACCEPT) accepted_frames++;
        else dropped_frames++;
        if (expected_beats.size() == 0) begin
          fail_count++;
          if (fail_count <= 20)
            $display("%0t: unexpected beat kind %0d data %02h len %0d", $realtime,
                     got.kind, got.data_byte, got.frame_length);
        end else begin
          want = expected_beats.pop_front();
          bad = 1'b0;
          if (got.kind !== want.kind) begin
            bad = 1'b1;
            if (fail_count < 20)
              $display("%0t: kind expected %0d actual %0d", $realtime, want.kind, got.kind);
          end
          if (got.data_byte !== want.data_byte) begin
            bad = 1'b1;
            if (fail_count < 20)
              $display("%0t: data_byte expected %02h actual %02h", $realtime,
                       want.data_byte, got.data_byte);
          end
          if (got.frame_length !== want.frame_length) begin
            bad = 1'b1;
            if (fail_count < 20)
              $display("%0t: frame_length expected %0d actual %0d", $realtime,
                       want.frame_length, got.frame_length);
          end
          if (bad) fail_count++;
        end
      end
      if (in_valid && in_ready) begin
        if (deframe_byte(in_byte, want)) expected_beats.push_back(want);
      end
      if (cfg_wr_en) accept_limit = cfg_wr_data;
    end
    pending <= expected_beats.size();
  end

endmodule

FILE: tb/sv/tb.sv
// Top of the frame receiver testbench: clock, reset, link byte stimulus,
// output back-pressure and the verdict.
// Depends on lpfr_pkg, lpfr_if, length_prefixed_frame_receiver_unit, lpfr_frame_checker.

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lpfr_pkg::*;

  localparam int NUM_PHASES   = 7;
  localparam int PHASE_BUDGET = 30;  // random link bytes per limit setting

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [LEN_W-1:0] cfg_wr_data;

  lpfr_in_if  in_bus();
  lpfr_out_if out_bus();

  int chk_fail;
  int chk_pending;
  int n_payload;
  int n_accepted;
  int n_dropped;

  int          items_sent;
  int          gap_pct;      // chance of a sender gap after each beat
  bit          hold_output;  // asks the receiver for one long hold-off
  int unsigned limit_now;

  length_prefixed_frame_receiver_unit #(
    .MAX_PAYLOAD(512)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .out_bus    (out_bus),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  lpfr_frame_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_bus.valid),
    .in_ready       (in_bus.ready),
    .in_byte        (in_bus.rx_byte),
    .out_valid      (out_bus.valid),
    .out_ready      (out_bus.ready),
    .out_kind       (out_bus.kind),
    .out_data       (out_bus.data_byte),
    .out_len        (out_bus.frame_length),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .fail_count     (chk_fail),
    .pending        (chk_pending),
    .payload_beats  (n_payload),
    .accepted_frames(n_accepted),
    .dropped_frames (n_dropped)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop, well beyond the slowest legal run (every beat stalled, long gaps).
  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

  // Offer one link byte from a falling edge and hold it until accepted, then
  // perhaps leave a gap. Always returns on a falling edge.
  task automatic push_byte(input logic [7:0] b);
    int n;
    in_bus.valid   <= 1'b1;
    in_bus.rx_byte <= b;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    @(negedge clk);
    items_sent++;
    if ($urandom_range(0, 99) < gap_pct) begin
      // mostly short gaps, the odd long one
      if ($urandom_range(0, 99) < 85) n = $urandom_range(1, 3);
      else n = $urandom_range(8, 30);
      in_bus.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Stop sending and let every predicted beat drain. Header bytes make no
  // beat, so a byte may still sit in the input register: keep waiting after the queue empties.
  task automatic drain_block();
    in_bus.valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input int unsigned v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[LEN_W-1:0];
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    limit_now = v;
  endtask

  // Declared length for a random frame: mostly short, some around a small
  // limit, a few zero or beyond the maximum payload.
  function automatic logic [15:0] pick_length(input int unsigned lim);
    int unsigned r;
    int unsigned lo;
    r = $urandom_range(0, 99);
    if (r < 4) return 16'd0;
    if (r < 8) return 16'($urandom_range(513, 65535));
    if (r < 25 && lim <= 20) begin
      lo = (lim > 1) ? lim - 1 : 1;
      return 16'($urandom_range(lo, lim + 1));
    end
    return 16'($urandom_range(1, 12));
  endfunction

  // A frame with a little line noise in front of it. Zero and oversized
  // lengths stop after the header, as the parser goes back to hunting there.
  task automatic send_frame(input logic [15:0] len);
    int n;
    logic [7:0] b;
    n = $urandom_range(0, 2);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) b = FRAME_DELIM;
      else b = 8'($urandom_range(0, 255));
      push_byte(b);
    end
    push_byte(FRAME_DELIM);
    push_byte(len[15:8]);
    push_byte(len[7:0]);
    if (len == 0 || len > 512) return;
    repeat (len) begin
      // delimiters inside the payload are plain data
      if ($urandom_range(0, 9) == 0) b = FRAME_DELIM;
      else b = 8'($urandom_range(0, 255));
      push_byte(b);
    end
    if ($urandom_range(0, 99) < 88) b = FRAME_DELIM;
    else b = 8'($urandom_range(0, 255));
    push_byte(b);
  endtask

  // Receiver: runs of full readiness, random readiness, short stalls, and
  // one long hold-off on request so the block backs up into in_bus.ready.
  initial begin
    int ready_run;
    int stall_run;
    int r;
    ready_run = 0;
    stall_run = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_bus.ready <= 1'b0;
        repeat (80) @(negedge clk);
        hold_output = 1'b0;
      end else if (ready_run > 0) begin
        out_bus.ready <= 1'b1;
        ready_run--;
      end else if (stall_run > 0) begin
        out_bus.ready <= 1'b0;
        stall_run--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) ready_run = $urandom_range(20, 60);
        else if (r < 14) stall_run = $urandom_range(8, 25);
        out_bus.ready <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned limits[NUM_PHASES];
    int          gap_plan[NUM_PHASES];
    int          phase_start;
    // Opening sequence: hunted noise at both byte extremes; a one-byte frame
    // whose payload is the delimiter; a zero length, then the next delimiter
    // taken as a fresh start; lengths 513 and 0xFFFF; a frame of 0xFF, 0x00
    // whose end byte is not the delimiter.
    logic [7:0]  opening[22] = '{8'h00, 8'hFF,
                                 8'h7E, 8'h00, 8'h01, 8'h7E, 8'h7E,
                                 8'h7E, 8'h00, 8'h00,
                                 8'h7E, 8'h02, 8'h01,
                                 8'h7E, 8'hFF, 8'hFF,
                                 8'h7E, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h55};

    // reset value first, then both extremes, small limits and the max payload
    limits   = '{65535, 0, 1, 6, $urandom_range(2, 20), 512, 65535};
    gap_plan = '{30, 0, 60, 0, 30, 10, 40};

    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_bus.valid   = 1'b0;
    in_bus.rx_byte = '0;
    hold_output    = 1'b0;
    items_sent     = 0;
    gap_pct        = 0;
    limit_now      = 65535;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (opening[i]) push_byte(opening[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // limit changes only with the block drained; also the sender's full pause
      drain_block();
      if (p > 0) write_limit(limits[p]);
      gap_pct = gap_plan[p];
      // back-to-back bytes against a long output hold-off
      if (p == 1) hold_output = 1'b1;
      phase_start = items_sent;
      // longest legal frame, accepted at a limit of exactly the max payload
      if (limits[p] == 512) send_frame(16'd512);
      while (items_sent - phase_start < PHASE_BUDGET)
        send_frame(pick_length(limit_now));
    end

    drain_block();
    repeat (10) @(negedge clk);

    $display("summary: %0d link bytes over %0d limit settings (0 to 65535)",
             items_sent, NUM_PHASES);
    $display("summary: %0d payload beats, %0d frames accepted, %0d dropped at end",
             n_payload, n_accepted, n_dropped);
    if (chk_fail == 0 && chk_pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/lpfr_pkg.sv
hdl/lpfr_if.sv
hdl/lpfr_in_stage.sv
hdl/lpfr_parser.sv
hdl/lpfr_out_stage.sv
hdl/length_prefixed_frame_receiver_unit.sv
tb/sv/lpfr_frame_checker.sv
tb/sv/tb.sv
